// ----- rtl/ghash_pkg.sv -----
// Shared definitions for the GHASH GF(2^128) accumulator.
// Holds field constants, the controller state type and the multiply digit step.
// Depends on nothing.
package ghash_pkg;

	localparam int GF_BITS    = 128;
	localparam int HALF_BITS  = GF_BITS / 2;
	localparam int DIGIT_BITS = 8;
	localparam int DIGITS     = GF_BITS / DIGIT_BITS;
	localparam int CNT_W      = $clog2(DIGITS);
	localparam int BYTES      = GF_BITS / 8;
	localparam int NBYTES_W   = 5;

	localparam logic [7:0] GF_REDUCE = 8'hE1;

	localparam logic [CNT_W-1:0] LAST_DIGIT = CNT_W'(DIGITS - 1);

	localparam logic REG_SUBKEY_HI = 1'b0;
	localparam logic REG_SUBKEY_LO = 1'b1;

	typedef logic [GF_BITS-1:0] gf_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	typedef struct packed {
		gf_t z;
		gf_t v;
	} mul_acc_t;

	// One digit of the multiply: multiplier bits are taken MSB first, and V is
	// multiplied by x after each bit, with the reflected reduction of GCM.
	function automatic mul_acc_t gf_digit_step(mul_acc_t cur, logic [DIGIT_BITS-1:0] digit);
		mul_acc_t acc;
		logic carry;
		acc = cur;
		for (int i = DIGIT_BITS - 1; i >= 0; i--) begin
			if (digit[i]) begin
				acc.z = acc.z ^ acc.v;
			end
			carry = acc.v[0];
			acc.v = acc.v >> 1;
			if (carry) begin
				acc.v[GF_BITS-1 -: 8] = acc.v[GF_BITS-1 -: 8] ^ GF_REDUCE;
			end
		end
		return acc;
	endfunction

	// Keeps the leading bytes of a block; byte 0 sits in the top bits.
	// A count of sixteen or more keeps the whole block.
	function automatic gf_t mask_block(gf_t blk, logic [NBYTES_W-1:0] nbytes);
		gf_t res;
		res = blk;
		for (int k = 0; k < BYTES; k++) begin
			if (nbytes <= NBYTES_W'(k)) begin
				res[GF_BITS-1-8*k -: 8] = 8'h00;
			end
		end
		return res;
	endfunction

endpackage

// ----- rtl/ghash_gf128_accumulator.sv -----
// Top level of the GHASH GF(2^128) accumulator.
// Uses ghash_pkg for constants, the state type and the digit step of the multiply.
//
// Each item carries a 128-bit block that is masked to its leading valid bytes,
// XORed into the running hash Y (cleared first when first is set) and multiplied
// by the subkey H. The multiply walks the multiplier eight bits per cycle out of
// a shift register. The block takes no new item while one is in the multiply;
// the next item is accepted once its result is loaded and the block is idle again.
// A result held in the output register does not block the next item; only a
// second finished result stalls until the first is taken. The user must write
// H through the configuration port only while the block is idle; the block
// itself does not enforce this. Reset clears H and Y to zero.
module ghash_gf128_accumulator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_index,
	input  logic [63:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] block_hi,
	input  logic [63:0] block_lo,
	input  logic [4:0]  valid_bytes,
	input  logic        first,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] hash_hi,
	output logic [63:0] hash_lo
);

	ghash_pkg::state_t state_q, state_d;

	logic [ghash_pkg::HALF_BITS-1:0] subkey_hi_q, subkey_lo_q;
	ghash_pkg::gf_t acc_q;
	ghash_pkg::gf_t x_q;
	ghash_pkg::mul_acc_t mul_q, mul_next;
	logic [ghash_pkg::CNT_W-1:0] cnt_q;
	ghash_pkg::gf_t hash_q;
	logic out_valid_q;

	logic in_fire;
	logic last_digit;
	logic out_free;
	logic finish;
	ghash_pkg::gf_t y_start;

	assign in_fire    = in_valid && in_ready;
	assign last_digit = (cnt_q == ghash_pkg::LAST_DIGIT);
	assign out_free   = !out_valid_q || out_ready;
	assign mul_next   = ghash_pkg::gf_digit_step(mul_q,
		x_q[ghash_pkg::GF_BITS-1 -: ghash_pkg::DIGIT_BITS]);
	assign y_start    = (first ? '0 : acc_q) ^
		ghash_pkg::mask_block({block_hi, block_lo}, valid_bytes);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ghash_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = ghash_pkg::ST_RUN;
				end
			end
			ghash_pkg::ST_RUN: begin
				if (last_digit && out_free) begin
					state_d = ghash_pkg::ST_IDLE;
				end
			end
			default: state_d = ghash_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		finish   = 1'b0;
		case (state_q)
			ghash_pkg::ST_IDLE: in_ready = 1'b1;
			ghash_pkg::ST_RUN:  finish   = last_digit && out_free;
			default: begin
				in_ready = 1'b0;
				finish   = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ghash_pkg::ST_IDLE;
			subkey_hi_q <= '0;
			subkey_lo_q <= '0;
			acc_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				case (cfg_index)
					ghash_pkg::REG_SUBKEY_HI: subkey_hi_q <= cfg_wdata;
					ghash_pkg::REG_SUBKEY_LO: subkey_lo_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (in_fire) begin
				cnt_q <= '0;
			end else if (state_q == ghash_pkg::ST_RUN && !last_digit) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (finish) begin
				acc_q       <= mul_next.z;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers carry no reset; x_q and mul_q load as an item starts.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			x_q     <= y_start;
			mul_q.z <= '0;
			mul_q.v <= {subkey_hi_q, subkey_lo_q};
		end else if (state_q == ghash_pkg::ST_RUN && !last_digit) begin
			x_q   <= x_q << ghash_pkg::DIGIT_BITS;
			mul_q <= mul_next;
		end
		if (finish) begin
			hash_q <= mul_next.z;
		end
	end

	assign out_valid = out_valid_q;
	assign hash_hi   = hash_q[ghash_pkg::GF_BITS-1 -: ghash_pkg::HALF_BITS];
	assign hash_lo   = hash_q[ghash_pkg::HALF_BITS-1:0];

endmodule
